[rtl/cccb_pkg.sv]
// Shared types and constants for the CAN capture buffer.
`timescale 1ns / 1ps
`default_nettype none
package cccb_pkg;

	localparam int DEPTH   = 256;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int LEN_W   = 9;
	localparam int LEN_CAP = (DEPTH > 511) ? 511 : DEPTH;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int MS_W    = 32;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_READ  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_TICK  = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUF_LEN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EVT_ENABLE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EVT_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EVT_TIMEOUT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_EVT_DELAY   = 3'd5;

	typedef struct packed {
		logic [3:0]  len;
		logic [7:0]  flags;
		logic [28:0] id;
	} msg_hdr_t;

	typedef struct packed {
		logic        enabled;
		logic [15:0] count_limit;
		logic [15:0] timeout_ms;
		logic [15:0] delay_ms;
	} evt_cfg_t;

	typedef struct packed {
		logic add;   // a message was stored
		logic tick;  // one millisecond passed
	} evt_req_t;

endpackage
`default_nettype wire

[rtl/can_capture_buffer_with_event_coalescing.sv]
// Top level: CAN capture buffer with linear/overwrite modes and coalesced events.
//
//  channel   signals                               direction  handshake
//  request   start/busy, mode, read_index, in_*    in         start & !busy
//  result    done, status, out_*, held_count,      out        done (one cycle)
//            event_fired
//  config    cfg_valid/cfg_ready, cfg_index,       in         cfg_valid & cfg_ready
//            cfg_data
//
// One request per cycle; busy is never raised. The result appears in the cycle
// after the request is taken, set by the registered read port of the store.
// Reset clears positions, counters and timers; the message memories are not
// cleared and a never-written slot reads as garbage.
// The receiver cannot stall: done is a one-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none
module can_capture_buffer_with_event_coalescing
	import cccb_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// request
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [1:0]           mode,
	input  wire logic [7:0]           read_index,
	input  wire logic [28:0]          in_id,
	input  wire logic [7:0]           in_flags,
	input  wire logic [3:0]           in_length,
	input  wire logic [63:0]          in_payload,
	// result
	output logic                      done,
	output logic                      status,
	output logic [28:0]               out_id,
	output logic [7:0]                out_flags,
	output logic [3:0]                out_length,
	output logic [63:0]               out_payload,
	output logic [LEN_W-1:0]          held_count,
	output logic                      event_fired,
	// configuration
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	// config registers
	logic             overwrite_q;
	logic [LEN_W-1:0] buf_len_q;
	evt_cfg_t         evt_cfg_q;

	// store position
	logic [LEN_W-1:0] wp_q, wp_d;
	logic             wrap_q, wrap_d;

	// result stage
	logic             valid_s1, status_s1, read_ok_s1, fired_s1;
	logic [LEN_W-1:0] held_s1;

	logic             accept, cfg_we;
	mode_t            req_mode;
	logic [LEN_W-1:0] eff_len, wp_base, wp_inc, slot, held_d;
	logic [LEN_W:0]   rsum;
	logic             at_end, store_we, read_ok, status_d, fired;
	evt_req_t         evt_req;
	msg_hdr_t         whdr, rhdr_q;
	logic [63:0]      rpay_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign req_mode  = mode_t'(mode);

	// length register: zero acts as one, oversize acts as the memory depth
	always_comb begin
		if (buf_len_q == '0)
			eff_len = LEN_W'(1);
		else if (buf_len_q > LEN_W'(LEN_CAP))
			eff_len = LEN_W'(LEN_CAP);
		else
			eff_len = buf_len_q;
	end

	always_comb begin
		wp_d     = wp_q;
		wrap_d   = wrap_q;
		store_we = 1'b0;
		read_ok  = 1'b0;
		status_d = 1'b0;
		slot     = LEN_W'(read_index);
		at_end   = wp_q >= eff_len;
		// overwrite restarts at slot 0 when past the end (e.g. after mode switch)
		wp_base  = at_end ? '0 : wp_q;
		wp_inc   = wp_base + LEN_W'(1);
		// oldest-first read: physical slot = index + write position, mod length
		rsum     = (LEN_W+1)'(read_index) + (LEN_W+1)'(wp_q);
		if (accept) begin
			case (req_mode)
				MODE_ADD: begin
					if (overwrite_q) begin
						store_we = 1'b1;
						slot     = wp_base;
						if (wp_inc >= eff_len) begin
							wp_d   = '0;
							wrap_d = 1'b1;
						end else begin
							wp_d   = wp_inc;
							wrap_d = wrap_q | at_end;
						end
					end else if (!at_end) begin
						store_we = 1'b1;
						slot     = wp_q;
						wp_d     = wp_inc;
					end else begin
						status_d = 1'b1;
					end
				end
				MODE_READ: begin
					if (overwrite_q && wrap_q) begin
						read_ok = LEN_W'(read_index) < eff_len;
						if (rsum >= (LEN_W+1)'(eff_len))
							slot = LEN_W'(rsum - (LEN_W+1)'(eff_len));
						else
							slot = LEN_W'(rsum);
					end else begin
						read_ok = LEN_W'(read_index) < wp_q;
					end
					status_d = !read_ok;
				end
				MODE_CLEAR: begin
					wp_d   = '0;
					wrap_d = 1'b0;
				end
				MODE_TICK: begin
				end
				default: begin
				end
			endcase
		end
		held_d = (overwrite_q && wrap_d) ? eff_len : wp_d;
	end

	assign evt_req.add  = store_we;
	assign evt_req.tick = accept && (req_mode == MODE_TICK);

	assign whdr.id    = in_id;
	assign whdr.flags = in_flags;
	assign whdr.len   = in_length;

	cccb_store u_store (
		.clk    (clk),
		.we     (store_we),
		.waddr  (ADDR_W'(slot)),
		.whdr   (whdr),
		.wpay   (in_payload),
		.re     (read_ok),
		.raddr  (ADDR_W'(slot)),
		.rhdr_q (rhdr_q),
		.rpay_q (rpay_q)
	);

	cccb_events u_events (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (evt_cfg_q),
		.req    (evt_req),
		.fired  (fired)
	);

	// position and config; a length write empties the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			wrap_q      <= 1'b0;
			overwrite_q <= 1'b0;
			buf_len_q   <= LEN_W'(256);
			evt_cfg_q   <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_BUF_LEN) begin
				wp_q   <= '0;
				wrap_q <= 1'b0;
			end else begin
				wp_q   <= wp_d;
				wrap_q <= wrap_d;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_OVERWRITE:   overwrite_q <= cfg_data[0];
					CFG_BUF_LEN:     buf_len_q   <= cfg_data[LEN_W-1:0];
					CFG_EVT_ENABLE:  evt_cfg_q.enabled     <= cfg_data[0];
					CFG_EVT_LIMIT:   evt_cfg_q.count_limit <= cfg_data;
					CFG_EVT_TIMEOUT: evt_cfg_q.timeout_ms  <= cfg_data;
					CFG_EVT_DELAY:   evt_cfg_q.delay_ms    <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1  <= status_d;
			read_ok_s1 <= read_ok;
			held_s1    <= held_d;
			fired_s1   <= fired;
		end
	end

	assign done        = valid_s1;
	assign status      = status_s1;
	assign held_count  = held_s1;
	assign event_fired = fired_s1;
	assign out_id      = read_ok_s1 ? rhdr_q.id    : '0;
	assign out_flags   = read_ok_s1 ? rhdr_q.flags : '0;
	assign out_length  = read_ok_s1 ? rhdr_q.len   : '0;
	assign out_payload = read_ok_s1 ? rpay_q       : '0;

`ifndef SYNTHESIS
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start))
		else $error("result strobe without a request");
	a_wp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= eff_len)
		else $error("write position beyond buffer length");
	a_refused_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (out_payload == '0 && out_id == '0))
		else $error("refused request carries message data");
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> held_count <= eff_len)
		else $error("held count exceeds buffer length");
`endif

endmodule
`default_nettype wire

[rtl/cccb_store.sv]
// Message store: header and payload memories, one write and one registered read.
`timescale 1ns / 1ps
`default_nettype none
module cccb_store
	import cccb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire msg_hdr_t          whdr,
	input  wire logic [63:0]       wpay,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output msg_hdr_t               rhdr_q,
	output logic [63:0]            rpay_q
);

	msg_hdr_t    hdr_mem [DEPTH];
	logic [63:0] pay_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			hdr_mem[waddr] <= whdr;
			pay_mem[waddr] <= wpay;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rhdr_q <= hdr_mem[raddr];
			rpay_q <= pay_mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/cccb_events.sv]
// Event coalescing: pending count, count limit, millisecond clock, timeout and quiet deadline.
`timescale 1ns / 1ps
`default_nettype none
module cccb_events
	import cccb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire evt_cfg_t cfg,
	input  wire evt_req_t req,
	output logic          fired
);

	logic [15:0]     pending_q, pending_in, pending_d;
	logic [MS_W-1:0] now_q, now_in;
	logic [MS_W-1:0] last_q, last_d;
	logic [MS_W-1:0] deadline_q, deadline_d;
	logic [MS_W-1:0] since_deadline, elapsed;
	logic            armed_q, armed_d;
	logic            nds_q, nds_in, nds_d;
	logic            due, eval, hit_lim, hit_to;

	always_comb begin
		pending_in = pending_q;
		if (req.add && pending_q != 16'hFFFF)
			pending_in = pending_q + 16'd1;
		nds_in = req.add | nds_q;
		now_in = req.tick ? now_q + MS_W'(1) : now_q;

		since_deadline = now_in - deadline_q;
		due     = armed_q && !since_deadline[MS_W-1];
		eval    = cfg.enabled && (req.add || (req.tick && due));
		elapsed = now_in - last_q;
		hit_lim = (cfg.count_limit != 16'd0) && (pending_in >= cfg.count_limit);
		hit_to  = (pending_in != 16'd0) && (elapsed >= MS_W'(cfg.timeout_ms));

		fired      = 1'b0;
		pending_d  = pending_in;
		nds_d      = nds_in;
		armed_d    = armed_q;
		deadline_d = deadline_q;
		last_d     = last_q;
		if (eval) begin
			armed_d = 1'b0;
			nds_d   = 1'b0;
			if (hit_lim || hit_to) begin
				fired = 1'b1;
			end else if (nds_in) begin
				deadline_d = now_in + MS_W'(cfg.delay_ms);
				armed_d    = 1'b1;
			end else if (pending_in != 16'd0) begin
				fired = 1'b1;
			end
		end
		if (fired) begin
			pending_d = 16'd0;
			last_d    = now_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			now_q      <= '0;
			last_q     <= '0;
			deadline_q <= '0;
			armed_q    <= 1'b0;
			nds_q      <= 1'b0;
		end else begin
			pending_q  <= pending_d;
			now_q      <= now_in;
			last_q     <= last_d;
			deadline_q <= deadline_d;
			armed_q    <= armed_d;
			nds_q      <= nds_d;
		end
	end

`ifndef SYNTHESIS
	a_fire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fired |=> pending_q == 16'd0)
		else $error("pending count not cleared after event");
	a_tick_advances: assert property (@(posedge clk) disable iff (!arst_n)
		req.tick |=> now_q == $past(now_q) + MS_W'(1))
		else $error("millisecond clock did not advance on tick");
`endif

endmodule
`default_nettype wire
